// ===== hw/rtl/cls_pkg.sv =====
// ---------------------------------------------------------------------------
// cls_pkg
// Shared types and codes for the compacting list store.
// ---------------------------------------------------------------------------
package cls_pkg;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;

    localparam logic [POS_W-1:0] NO_POSITION = '1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_DELETE = 3'd1,
        OP_REMOVE = 3'd2,
        OP_FIND   = 3'd3,
        OP_GET    = 3'd4,
        OP_SET    = 3'd5,
        OP_CLEAR  = 3'd6
    } cls_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } cls_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MATCH,
        FSM_FINISH
    } cls_fsm_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic sample;
        logic live;
    } cls_cell_ctl_t;

endpackage

// ===== hw/rtl/cls_if.sv =====
// ---------------------------------------------------------------------------
// cls_if
// Request and response channels of the compacting list store.
// ---------------------------------------------------------------------------
interface cls_req_if;
    logic                          valid;
    logic                          ready;
    logic [cls_pkg::OP_W-1:0]      operation;
    logic [cls_pkg::INDEX_W-1:0]   index;
    logic [cls_pkg::VALUE_W-1:0]   item_value;

    modport source (output valid, output operation, output index, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input index, input item_value,
                    output ready);
endinterface

interface cls_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cls_pkg::STATUS_W-1:0]  status;
    logic [cls_pkg::POS_W-1:0]     position;
    logic [cls_pkg::VALUE_W-1:0]   read_value;
    logic [cls_pkg::COUNT_W-1:0]   item_count;

    modport source (output valid, output status, output position, output read_value,
                    output item_count, input ready);
    modport sink   (input valid, input status, input position, input read_value,
                    input item_count, output ready);
endinterface

// ===== hw/rtl/compacting_list_store_unit.sv =====
// Each request is accepted, compared in the cell row, then updated and answered;
// a new request is taken only after the current one has finished.
// The match stage in the cell row is registered; a stalled response holds the update.
// Reset clears the item count, FSM and response valid; cell entries are not cleared.
// Entries are only read below the item count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// compacting_list_store_unit
// Dense ordered list in a row of cells with append, delete, remove, find, get, set and clear.
// ---------------------------------------------------------------------------
module compacting_list_store_unit #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    cls_req_if.sink    req,
    cls_rsp_if.source  rsp
);
    import cls_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int VW = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;

    cls_fsm_t state_reg, state_next;

    cls_op_t               op_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [ITEM_WIDTH-1:0] val_reg;
    logic [CW-1:0]         count_reg, count_next;

    logic                  out_valid_reg;
    cls_status_t           status_reg, status_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [VALUE_W-1:0]    rd_reg, rd_next;

    logic in_ready, sample, finish_go;

    logic [ITEM_WIDTH-1:0] entry [CAPACITY];
    logic [ITEM_WIDTH-1:0] upper [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    cls_cell_ctl_t         ctl   [CAPACITY];

    logic          hit_found;
    logic [PW-1:0] hit_pos;

    logic [XW-1:0]         idx_x, cnt_x, gap_x, load_x;
    logic                  idx_ok, full, do_shift, do_load;
    logic [ITEM_WIDTH-1:0] rd_sel;

    // ---- FSM ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:   if (req.valid) state_next = FSM_MATCH;
            FSM_MATCH:  state_next = FSM_FINISH;
            FSM_FINISH: if (finish_go) state_next = FSM_IDLE;
            default:    state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        sample    = 1'b0;
        finish_go = 1'b0;
        unique case (state_reg)
            FSM_IDLE:   in_ready  = 1'b1;
            FSM_MATCH:  sample    = 1'b1;
            FSM_FINISH: finish_go = !out_valid_reg || rsp.ready;
            default:    ;
        endcase
    end

    assign req.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && in_ready)
        begin
            op_reg  <= cls_op_t'(req.operation);
            idx_reg <= req.index;
            val_reg <= ITEM_WIDTH'(req.item_value[VW-1:0]);
        end
        if (finish_go)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            rd_reg     <= rd_next;
        end
    end

    // ---- cell row ----
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_top
            assign upper[i] = entry[i];
        end
        else
        begin : g_mid
            assign upper[i] = entry[i+1];
        end

        always_comb
        begin
            ctl[i].shift  = finish_go && do_shift && (XW'(i) >= gap_x);
            ctl[i].load   = finish_go && do_load && (XW'(i) == load_x);
            ctl[i].sample = sample;
            ctl[i].live   = XW'(i) < cnt_x;
        end

        cls_cell #(
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl[i]),
            .upper (upper[i]),
            .wdata (val_reg),
            .cmp   (val_reg),
            .entry (entry[i]),
            .match (match_vec[i])
        );
    end

    cls_first_hit #(
        .N (CAPACITY)
    ) u_first_hit (
        .vec   (match_vec),
        .found (hit_found),
        .pos   (hit_pos)
    );

    // ---- get readout ----
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_sel = rd_sel | (entry[i] & {ITEM_WIDTH{XW'(i) == idx_x}});
        end
    end

    // ---- operation decode ----
    assign idx_x  = XW'(idx_reg);
    assign cnt_x  = XW'(count_reg);
    assign idx_ok = idx_x < cnt_x;
    assign full   = count_reg == CW'(CAPACITY);

    always_comb
    begin
        status_next = STAT_OK;
        pos_next    = NO_POSITION;
        rd_next     = '0;
        count_next  = count_reg;
        gap_x       = '0;
        load_x      = '0;
        do_shift    = 1'b0;
        do_load     = 1'b0;
        unique case (op_reg)
            OP_APPEND:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    do_load    = 1'b1;
                    load_x     = cnt_x;
                    pos_next   = POS_W'(count_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                if (!idx_ok)
                begin
                    status_next = STAT_BAD_INDEX;
                end
                else
                begin
                    do_shift   = 1'b1;
                    gap_x      = idx_x;
                    pos_next   = POS_W'(idx_reg);
                    count_next = count_reg - CW'(1);
                end
            end
            OP_REMOVE, OP_FIND:
            begin
                if (!hit_found)
                begin
                    status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    pos_next = POS_W'(hit_pos);
                    if (op_reg == OP_REMOVE)
                    begin
                        do_shift   = 1'b1;
                        gap_x      = XW'(hit_pos);
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            OP_GET, OP_SET:
            begin
                if (!idx_ok)
                begin
                    status_next = STAT_BAD_INDEX;
                end
                else
                begin
                    pos_next = POS_W'(idx_reg);
                    if (op_reg == OP_GET)
                    begin
                        rd_next = VALUE_W'(rd_sel[VW-1:0]);
                    end
                    else
                    begin
                        do_load = 1'b1;
                        load_x  = idx_x;
                    end
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default: ;
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.position   = pos_reg;
    assign rsp.read_value = rd_reg;
    assign rsp.item_count = COUNT_W'(count_reg);

endmodule

// ===== hw/rtl/cls_cell.sv =====
// ---------------------------------------------------------------------------
// cls_cell
// One list slot: holds an entry, shifts from its upper neighbor or loads new data, compares.
// ---------------------------------------------------------------------------
module cls_cell #(
    parameter int ITEM_WIDTH = 32
) (
    input  logic                    clk,
    input  cls_pkg::cls_cell_ctl_t  ctl,
    input  logic [ITEM_WIDTH-1:0]   upper,
    input  logic [ITEM_WIDTH-1:0]   wdata,
    input  logic [ITEM_WIDTH-1:0]   cmp,
    output logic [ITEM_WIDTH-1:0]   entry,
    output logic                    match
);
    import cls_pkg::*;

    logic [ITEM_WIDTH-1:0] entry_reg;
    logic                  match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            entry_reg <= upper;
        end
        else if (ctl.load)
        begin
            entry_reg <= wdata;
        end
        if (ctl.sample)
        begin
            match_reg <= ctl.live && (entry_reg == cmp);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/cls_first_hit.sv =====
// ---------------------------------------------------------------------------
// cls_first_hit
// Lowest set bit of the cell match vector and its position.
// ---------------------------------------------------------------------------
module cls_first_hit #(
    parameter int N = 64
) (
    input  logic [N-1:0]         vec,
    output logic                 found,
    output logic [$clog2(N)-1:0] pos
);
    import cls_pkg::*;

    localparam int PW = $clog2(N);

    logic [N-1:0] lowest;

    assign lowest = vec & (~vec + N'(1));
    assign found  = |vec;

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < PW; b++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    pos[b] = pos[b] | lowest[i];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/cls_checker.sv =====
// ---------------------------------------------------------------------------
// cls_checker
// Port-level checks on the compacting list store, bound to the top level.
// ---------------------------------------------------------------------------
module cls_checker #(
    parameter int CAPACITY = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [cls_pkg::STATUS_W-1:0]  rsp_status,
    input logic [cls_pkg::POS_W-1:0]     rsp_position,
    input logic [cls_pkg::VALUE_W-1:0]   rsp_read_value,
    input logic [cls_pkg::COUNT_W-1:0]   rsp_item_count
);
    import cls_pkg::*;

    localparam bit SMALL = CAPACITY <= 64;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                    && $stable(rsp_item_count))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while one is in flight");

    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STAT_OK |-> rsp_position == NO_POSITION
                                              && rsp_read_value == '0)
        else $error("failed operation reports a position or data");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL |-> rsp_item_count <= COUNT_W'(CAPACITY))
        else $error("item count above capacity");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL && rsp_position != NO_POSITION
            |-> rsp_position <= rsp_item_count)
        else $error("position beyond item count");

endmodule

bind compacting_list_store_unit cls_checker #(
    .CAPACITY (CAPACITY)
) u_cls_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_position   (rsp.position),
    .rsp_read_value (rsp.read_value),
    .rsp_item_count (rsp.item_count)
);

// ===== bench/compacting_list_store_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// compacting_list_store_unit_test
// Drives append, delete, remove, find, get, set and clear requests into the
// list store with random gaps and response stalls. A shadow copy of the list
// predicts each response without a fixed expectation; every response beat is checked field by field.
// ---------------------------------------------------------------------------
module compacting_list_store_unit_test;

    import cls_pkg::*;

    localparam int               LIST_DEPTH     = 64;
    localparam int               DIRECTED_COUNT = 25;
    localparam int               RANDOM_ITEMS   = 1825;
    localparam int               HOLD_CYCLES    = 300;
    localparam int               TAIL_CYCLES    = 10;
    localparam int               CYCLE_LIMIT    = 300000;
    localparam logic [OP_W-1:0]  OP_NONE        = 3'd7;

    typedef struct packed {
        cls_status_t         status;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  item_count;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        logic                fixed;
        list_result_t        want;
    } stim_row_t;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_BLEND,
        MIX_SHRINK
    } phase_mix_t;

    localparam list_result_t ANY_RESULT = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cls_req_if req_ch ();
    cls_rsp_if rsp_ch ();

    compacting_list_store_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [VALUE_W-1:0] shadow_slots [LIST_DEPTH];
    int                 shadow_fill = 0;
    list_result_t       awaited_results [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 beat_count = 0;
    bit                 send_idle = 1'b1;
    bit                 recv_idle = 1'b1;
    bit                 hold_replies = 1'b0;
    bit                 req_fixed = 1'b0;
    list_result_t       req_want = '0;

    // Fixed expectations only where they follow directly from the list contents.
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{OP_GET,    6'd0,  32'h0000_0000, 1'b1, '{STAT_BAD_INDEX, NO_POSITION, 32'd0, 7'd0}},
        '{OP_DELETE, 6'd63, 32'h0000_0000, 1'b1, '{STAT_BAD_INDEX, NO_POSITION, 32'd0, 7'd0}},
        '{OP_FIND,   6'd0,  32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, NO_POSITION, 32'd0, 7'd0}},
        '{OP_REMOVE, 6'd0,  32'hFFFF_FFFF, 1'b1, '{STAT_NOT_FOUND, NO_POSITION, 32'd0, 7'd0}},
        '{OP_SET,    6'd0,  32'h1234_5678, 1'b1, '{STAT_BAD_INDEX, NO_POSITION, 32'd0, 7'd0}},
        '{OP_NONE,   6'd63, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,        NO_POSITION, 32'd0, 7'd0}},
        '{OP_APPEND, 6'd0,  32'h0000_0000, 1'b1, '{STAT_OK,        7'd0,        32'd0, 7'd1}},
        '{OP_APPEND, 6'd0,  32'hFFFF_FFFF, 1'b1, '{STAT_OK,        7'd1,        32'd0, 7'd2}},
        '{OP_APPEND, 6'd0,  32'h8000_0001, 1'b1, '{STAT_OK,        7'd2,        32'd0, 7'd3}},
        '{OP_APPEND, 6'd0,  32'hFFFF_FFFF, 1'b1, '{STAT_OK,        7'd3,        32'd0, 7'd4}},
        '{OP_FIND,   6'd0,  32'hFFFF_FFFF, 1'b0, ANY_RESULT},
        '{OP_GET,    6'd3,  32'h0000_0000, 1'b0, ANY_RESULT},
        '{OP_GET,    6'd4,  32'h0000_0000, 1'b0, ANY_RESULT},
        '{OP_SET,    6'd2,  32'h5A5A_5A5A, 1'b0, ANY_RESULT},
        '{OP_GET,    6'd2,  32'hFFFF_FFFF, 1'b0, ANY_RESULT},
        '{OP_REMOVE, 6'd0,  32'hFFFF_FFFF, 1'b0, ANY_RESULT},
        '{OP_FIND,   6'd0,  32'hFFFF_FFFF, 1'b0, ANY_RESULT},
        '{OP_DELETE, 6'd0,  32'h0000_0000, 1'b0, ANY_RESULT},
        '{OP_GET,    6'd0,  32'h0000_0000, 1'b0, ANY_RESULT},
        '{OP_DELETE, 6'd63, 32'h0000_0000, 1'b0, ANY_RESULT},
        '{OP_FIND,   6'd0,  32'h1234_5678, 1'b0, ANY_RESULT},
        '{OP_NONE,   6'd5,  32'h0000_0000, 1'b0, ANY_RESULT},
        '{OP_CLEAR,  6'd0,  32'h0000_0000, 1'b1, '{STAT_OK,        NO_POSITION, 32'd0, 7'd0}},
        '{OP_GET,    6'd0,  32'h0000_0000, 1'b1, '{STAT_BAD_INDEX, NO_POSITION, 32'd0, 7'd0}},
        '{OP_APPEND, 6'd63, 32'h0000_0001, 1'b1, '{STAT_OK,        7'd0,        32'd0, 7'd1}}
    };

    function automatic void close_shadow_gap(int at);
        for (int k = at; k + 1 < shadow_fill; k++)
            shadow_slots[k] = shadow_slots[k + 1];
        shadow_fill--;
    endfunction

    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic [INDEX_W-1:0] idx,
                                                   logic [VALUE_W-1:0] val);
        list_result_t r;
        int           hit;
        bit           idx_ok;
        r.status     = STAT_OK;
        r.position   = NO_POSITION;
        r.read_value = '0;
        idx_ok       = int'(idx) < shadow_fill;
        case (op)
            OP_APPEND:
                if (shadow_fill >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_slots[shadow_fill] = val;
                    r.position = shadow_fill[POS_W-1:0];
                    shadow_fill++;
                end
            OP_DELETE:
                if (!idx_ok)
                    r.status = STAT_BAD_INDEX;
                else
                begin
                    close_shadow_gap(int'(idx));
                    r.position = {1'b0, idx};
                end
            OP_REMOVE, OP_FIND:
            begin
                hit = -1;
                for (int k = 0; k < shadow_fill && hit < 0; k++)
                    if (shadow_slots[k] == val)
                        hit = k;
                if (hit < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    if (op == OP_REMOVE)
                        close_shadow_gap(hit);
                    r.position = hit[POS_W-1:0];
                end
            end
            OP_GET, OP_SET:
                if (!idx_ok)
                    r.status = STAT_BAD_INDEX;
                else
                begin
                    if (op == OP_GET)
                        r.read_value = shadow_slots[idx];
                    else
                        shadow_slots[idx] = val;
                    r.position = {1'b0, idx};
                end
            OP_CLEAR:
                shadow_fill = 0;
            default:
                ;
        endcase
        r.item_count = shadow_fill[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at beat %0d: got %h, expected %h", field, beat_count,
                 got, want);
        mismatch_count++;
    endtask

    // Request and response beats, both sampled at the rising edge
    always @(posedge clk)
    begin
        list_result_t head;
        list_result_t predicted;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("unrequested response", 32'd0, 32'd0);
                else
                begin
                    head = awaited_results.pop_front();
                    if (rsp_ch.status !== head.status)
                        report_mismatch("status", 32'(rsp_ch.status), 32'(head.status));
                    if (rsp_ch.position !== head.position)
                        report_mismatch("position", 32'(rsp_ch.position),
                                        32'(head.position));
                    if (rsp_ch.read_value !== head.read_value)
                        report_mismatch("read_value", rsp_ch.read_value, head.read_value);
                    if (rsp_ch.item_count !== head.item_count)
                        report_mismatch("item_count", 32'(rsp_ch.item_count),
                                        32'(head.item_count));
                end
                beat_count++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = apply_list_op(req_ch.operation, req_ch.index, req_ch.item_value);
                awaited_results.push_back(req_fixed ? req_want : predicted);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Response side: per-beat stall, plus one long hold on request
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (hold_replies)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_replies = 1'b0;
            end
            stall = recv_idle ? $urandom_range(0, 15) : 0;
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                logic [VALUE_W-1:0] val, logic fixed, list_result_t want);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.index      <= idx;
        req_ch.item_value <= val;
        req_fixed = fixed;
        req_want  = want;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int               sent;
        int               phase;
        int               len;
        int               pick;
        phase_mix_t       mix;
        logic [OP_W-1:0]  op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;

        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_APPEND;
        req_ch.index      = '0;
        req_ch.item_value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                         directed_rows[i].fixed, directed_rows[i].want);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mix = (phase == 0) ? MIX_GROW : phase_mix_t'($urandom_range(0, 2));
            len = (mix == MIX_GROW) ? $urandom_range(100, 140) : $urandom_range(30, 90);
            send_idle = $urandom_range(0, 9) < 7;
            recv_idle = $urandom_range(0, 9) < 7;
            if (phase == 2)
            begin
                send_idle    = 1'b0;
                hold_replies = 1'b1;
            end
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:
                        op = pick < 70 ? OP_APPEND : pick < 80 ? OP_FIND :
                             pick < 88 ? OP_GET : pick < 96 ? OP_SET :
                             pick < 98 ? OP_DELETE : OP_REMOVE;
                    MIX_SHRINK:
                        op = pick < 10 ? OP_APPEND : pick < 45 ? OP_DELETE :
                             pick < 75 ? OP_REMOVE : pick < 85 ? OP_FIND :
                             pick < 95 ? OP_GET : OP_SET;
                    default:
                        op = pick < 27 ? OP_APPEND : pick < 40 ? OP_DELETE :
                             pick < 52 ? OP_REMOVE : pick < 65 ? OP_FIND :
                             pick < 78 ? OP_GET : pick < 92 ? OP_SET :
                             pick < 95 ? OP_CLEAR : OP_NONE;
                endcase
                if (shadow_fill > 0 && $urandom_range(0, 3) != 0)
                    idx = INDEX_W'($urandom_range(0, shadow_fill - 1));
                else
                    idx = INDEX_W'($urandom_range(0, 63));
                pick = $urandom_range(0, 9);
                if (pick < 4 && shadow_fill > 0)
                    val = shadow_slots[$urandom_range(0, shadow_fill - 1)];
                else if (pick < 6)
                    val = VALUE_W'($urandom_range(0, 3));
                else
                    val = $urandom;
                send_request(op, idx, val, 1'b0, ANY_RESULT);
            end
            sent += len;
            if (phase == 2 || $urandom_range(0, 2) == 0)
                wait_drained();
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
